// ===== src/ccpi_pkg.sv =====
`timescale 1ns / 1ps
package ccpi_pkg;

  // error clamp and integral scaling
  localparam int ERROR_HIGH       = 1000;
  localparam int ERROR_LOW        = -1000;
  localparam int INTEGRAL_DIVISOR = 250;
  localparam int CV_OFFSET        = 18;

  // field widths
  localparam int TGT_W      = 13;
  localparam int VOLT_W     = 13;
  localparam int CURR_W     = 14;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int RAW_W   = 16;               // unclamped error
  localparam int ERR_W   = 14;               // clamped error, +/-1000
  localparam int P_W     = GAIN_W + ERR_W + 1;
  localparam int MAG_W   = GAIN_W + ERR_W - 1;
  localparam int RECIP_W = MAG_W + 1;
  localparam int DIV_W   = 11;
  localparam int Q_FRAC  = 12;
  localparam int INT_W   = 40;
  localparam int SUM_W   = INT_W + 1;
  localparam int CUR_W   = INT_W + 2;

  // reciprocal of the integral divisor, scaled by 2^MAG_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << MAG_W) / INTEGRAL_DIVISOR);
  localparam logic [DIV_W-1:0] DIV_K = DIV_W'(INTEGRAL_DIVISOR);

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_CC_RST = 16'd410;
  localparam logic [GAIN_W-1:0] GAIN_I_CC_RST = 16'd4;
  localparam logic [GAIN_W-1:0] GAIN_P_CV_RST = 16'd1638;
  localparam logic [GAIN_W-1:0] GAIN_I_CV_RST = 16'd2048;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST  = 9'd511;
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST  = 9'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CURRENT_TARGET,
    REG_VOLTAGE_TARGET,
    REG_GAIN_P_CC,
    REG_GAIN_I_CC,
    REG_GAIN_P_CV,
    REG_GAIN_I_CV,
    REG_DUTY_MAX,
    REG_DUTY_MIN
  } cfg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0]  current_target;
    logic [TGT_W-1:0]  voltage_target;
    logic [GAIN_W-1:0] gain_p_cc;
    logic [GAIN_W-1:0] gain_i_cc;
    logic [GAIN_W-1:0] gain_p_cv;
    logic [GAIN_W-1:0] gain_i_cv;
    logic [DUTY_W-1:0] duty_max;
    logic [DUTY_W-1:0] duty_min;
  } cfg_t;

  // error stage result
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       ki;
    logic                    cv;
    logic                    sw;
  } err_t;

  // proportional term and scaled integral increment
  typedef struct packed {
    logic signed [P_W-1:0]   p;
    logic signed [MAG_W:0]   dq;
    logic                    cv;
    logic                    sw;
  } quo_t;

endpackage

// ===== src/ccpi_cfg.sv =====
`timescale 1ns / 1ps
module ccpi_cfg
  import ccpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // register file, written one register per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_target <= '0;
      cfg_r.voltage_target <= '0;
      cfg_r.gain_p_cc      <= GAIN_P_CC_RST;
      cfg_r.gain_i_cc      <= GAIN_I_CC_RST;
      cfg_r.gain_p_cv      <= GAIN_P_CV_RST;
      cfg_r.gain_i_cv      <= GAIN_I_CV_RST;
      cfg_r.duty_max       <= DUTY_MAX_RST;
      cfg_r.duty_min       <= DUTY_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_CURRENT_TARGET: cfg_r.current_target <= cfg_wdata[TGT_W-1:0];
        REG_VOLTAGE_TARGET: cfg_r.voltage_target <= cfg_wdata[TGT_W-1:0];
        REG_GAIN_P_CC:      cfg_r.gain_p_cc      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I_CC:      cfg_r.gain_i_cc      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_P_CV:      cfg_r.gain_p_cv      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I_CV:      cfg_r.gain_i_cv      <= cfg_wdata[GAIN_W-1:0];
        REG_DUTY_MAX:       cfg_r.duty_max       <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_MIN:       cfg_r.duty_min       <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/ccpi_err.sv =====
`timescale 1ns / 1ps
module ccpi_err
  import ccpi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [VOLT_W-1:0]        in_voltage_mv,
  input  logic signed [CURR_W-1:0] in_current_ma,
  input  cfg_t                     cfg,
  output logic                     s1_valid,
  output err_t                     s1
);

  localparam logic signed [RAW_W-1:0] E_HI = RAW_W'(ERROR_HIGH);
  localparam logic signed [RAW_W-1:0] E_LO = RAW_W'(ERROR_LOW);

  logic                    cv_r;
  logic                    s1_valid_r;
  err_t                    s1_r;
  err_t                    s1_nxt;
  logic                    above;
  logic                    cv_now;
  logic signed [RAW_W-1:0] err_cv;
  logic signed [RAW_W-1:0] err_cc;
  logic signed [RAW_W-1:0] err_raw;
  logic signed [RAW_W-1:0] err_clip;

  // mode switch: first item above the voltage target moves to cv for good
  assign above  = in_voltage_mv > cfg.voltage_target;
  assign cv_now = cv_r | above;

  // raw error for both modes
  assign err_cv = $signed({{(RAW_W-TGT_W){1'b0}}, cfg.voltage_target})
                + $signed(RAW_W'(CV_OFFSET))
                - $signed({{(RAW_W-VOLT_W){1'b0}}, in_voltage_mv});
  assign err_cc = $signed({{(RAW_W-TGT_W){1'b0}}, cfg.current_target})
                - RAW_W'(in_current_ma);
  assign err_raw = cv_now ? err_cv : err_cc;

  // error clamp and gain selection
  always_comb begin
    if (err_raw > E_HI) begin
      err_clip = E_HI;
    end else if (err_raw < E_LO) begin
      err_clip = E_LO;
    end else begin
      err_clip = err_raw;
    end
    s1_nxt.err = err_clip[ERR_W-1:0];
    s1_nxt.kp  = cv_now ? cfg.gain_p_cv : cfg.gain_p_cc;
    s1_nxt.ki  = cv_now ? cfg.gain_i_cv : cfg.gain_i_cc;
    s1_nxt.cv  = cv_now;
    s1_nxt.sw  = ~cv_r & above;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r       <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        cv_r <= cv_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

// ===== src/ccpi_mul.sv =====
`timescale 1ns / 1ps
module ccpi_mul
  import ccpi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic s1_valid,
  input  err_t s1,
  output logic s4_valid,
  output quo_t s4
);

  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int REM_W  = MAG_W + DIV_W;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic [MAG_W-1:0]      mag;
    logic                  neg;
    logic                  cv;
    logic                  sw;
  } mag_t;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic [MAG_W-1:0]      mag;
    logic [MAG_W-1:0]      q0;
    logic                  neg;
    logic                  cv;
    logic                  sw;
  } est_t;

  logic [2:0]              vld_r;
  mag_t                    s2_r;
  mag_t                    s2_nxt;
  est_t                    s3_r;
  est_t                    s3_nxt;
  quo_t                    s4_r;
  quo_t                    s4_nxt;
  logic signed [ERR_W-1:0] e_abs;
  logic [PROD_W-1:0]       prod;
  logic [REM_W-1:0]        qd;
  logic [REM_W-1:0]        rem;
  logic [MAG_W-1:0]        q;

  // both gain products: signed proportional, unsigned integral magnitude
  always_comb begin
    e_abs      = s1.err[ERR_W-1] ? -s1.err : s1.err;
    s2_nxt.p   = $signed({1'b0, s1.kp}) * s1.err;
    s2_nxt.mag = s1.ki * e_abs[ERR_W-2:0];
    s2_nxt.neg = s1.err[ERR_W-1];
    s2_nxt.cv  = s1.cv;
    s2_nxt.sw  = s1.sw;
  end

  // quotient estimate by reciprocal, low by at most one
  always_comb begin
    prod       = s2_r.mag * RECIP;
    s3_nxt.p   = s2_r.p;
    s3_nxt.mag = s2_r.mag;
    s3_nxt.q0  = prod[2*MAG_W-1:MAG_W];
    s3_nxt.neg = s2_r.neg;
    s3_nxt.cv  = s2_r.cv;
    s3_nxt.sw  = s2_r.sw;
  end

  // remainder correction, then sign back on (truncates toward zero)
  always_comb begin
    qd        = s3_r.q0 * DIV_K;
    rem       = REM_W'(s3_r.mag) - qd;
    q         = s3_r.q0 + MAG_W'(rem >= REM_W'(DIV_K));
    s4_nxt.p  = s3_r.p;
    s4_nxt.dq = s3_r.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    s4_nxt.cv = s3_r.cv;
    s4_nxt.sw = s3_r.sw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign s4_valid = vld_r[2];
  assign s4       = s4_r;

endmodule

// ===== src/ccpi_acc.sv =====
`timescale 1ns / 1ps
module ccpi_acc
  import ccpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              s4_valid,
  input  quo_t              s4,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [DUTY_W-1:0] out_duty,
  output logic              out_voltage_mode,
  output logic              out_duty_clamped
);

  localparam int PAD_W = CUR_W - DUTY_W - Q_FRAC;
  localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam logic signed [CUR_W-1:0] HALF    = CUR_W'(1 << (Q_FRAC - 1));
  localparam logic signed [CUR_W-1:0] ROUND_N = CUR_W'((1 << Q_FRAC) - 1);

  logic [DUTY_W-1:0]       duty_r;
  logic signed [INT_W-1:0] integ_r;
  logic                    out_valid_r;
  logic [DUTY_W-1:0]       out_duty_r;
  logic                    out_mode_r;
  logic                    out_clamp_r;
  logic [DUTY_W-1:0]       duty_nxt;
  logic signed [INT_W-1:0] integ_nxt;
  logic                    clamp_nxt;
  logic signed [INT_W-1:0] integ_base;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] pi;
  logic signed [CUR_W-1:0] cur;
  logic signed [CUR_W-1:0] hi;
  logic signed [CUR_W-1:0] lo;
  logic signed [CUR_W-1:0] x;
  logic signed [CUR_W-1:0] xr;
  logic signed [CUR_W-1:0] step;

  // saturating integral, cleared on the switch into cv mode
  always_comb begin
    integ_base = s4.sw ? '0 : integ_r;
    sum        = SUM_W'(integ_base) + SUM_W'(s4.dq);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      integ_nxt = sum[SUM_W-1] ? INT_MIN : INT_MAX;
    end else begin
      integ_nxt = sum[INT_W-1:0];
    end
  end

  // duty update against the limits, else step by the rounded pi term
  always_comb begin
    pi   = SUM_W'(s4.p) + SUM_W'(integ_nxt);
    cur  = $signed({{PAD_W{1'b0}}, duty_r, {Q_FRAC{1'b0}}}) + CUR_W'(pi);
    hi   = $signed({{PAD_W{1'b0}}, cfg.duty_max, {Q_FRAC{1'b0}}});
    lo   = $signed({{PAD_W{1'b0}}, cfg.duty_min, {Q_FRAC{1'b0}}});
    x    = CUR_W'(pi) + HALF;
    xr   = x[CUR_W-1] ? x + ROUND_N : x;
    step = xr >>> Q_FRAC;
    if (cur >= hi) begin
      duty_nxt  = cfg.duty_max;
      clamp_nxt = 1'b1;
    end else if (cur <= lo) begin
      duty_nxt  = cfg.duty_min;
      clamp_nxt = 1'b1;
    end else begin
      duty_nxt  = duty_r + step[DUTY_W-1:0];
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_valid;
      if (s4_valid) begin
        duty_r  <= duty_nxt;
        integ_r <= integ_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv && s4_valid) begin
      out_duty_r  <= duty_nxt;
      out_mode_r  <= s4.cv;
      out_clamp_r <= clamp_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = out_duty_r;
  assign out_voltage_mode = out_mode_r;
  assign out_duty_clamped = out_clamp_r;

endmodule

// ===== src/cc_cv_pi_duty_controller.sv =====
`timescale 1ns / 1ps
// an accepted item passes five registers in order, s1, s2, s3, s4 and the result register,
// the first loaded at the edge that accepts it, and its result then stands on the out_ ports
// throughput: one item per cycle when not stalled; the five-stage pipeline holds as a whole while a result
// is stalled, so in_stall is out_stall gated by out_valid, in the same cycle
// reset (rst_n low, synchronous): constant-current mode, duty 0, integral 0,
// pipeline empty, registers at their default values
module cc_cv_pi_duty_controller
  import ccpi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VOLT_W-1:0]        in_voltage_mv,
  input  logic signed [CURR_W-1:0] in_current_ma,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DUTY_W-1:0]        out_duty,
  output logic                     out_voltage_mode,
  output logic                     out_duty_clamped,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  cfg_t cfg;
  err_t s1;
  quo_t s4;
  logic s1_valid;
  logic s4_valid;
  logic adv;

  // pipeline moves whenever the result slot is free or being taken
  assign adv      = ~out_valid | ~out_stall;
  assign in_stall = ~adv;

  ccpi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccpi_err u_err (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_voltage_mv (in_voltage_mv),
    .in_current_ma (in_current_ma),
    .cfg           (cfg),
    .s1_valid      (s1_valid),
    .s1            (s1)
  );

  ccpi_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s4_valid (s4_valid),
    .s4       (s4)
  );

  ccpi_acc u_acc (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .s4_valid         (s4_valid),
    .s4               (s4),
    .cfg              (cfg),
    .out_valid        (out_valid),
    .out_duty         (out_duty),
    .out_voltage_mode (out_voltage_mode),
    .out_duty_clamped (out_duty_clamped)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ccpi_pkg::*;

  localparam longint Q_ONE     = 4096;
  localparam longint INTEG_MAX = (longint'(1) <<< (INT_W - 1)) - 1;
  localparam longint INTEG_MIN = -(longint'(1) <<< (INT_W - 1));

  typedef struct packed {
    logic [VOLT_W-1:0]        v;
    logic signed [CURR_W-1:0] i;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              cv;
    logic              clamped;
  } duty_res_t;

  // dut ports
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [VOLT_W-1:0]        in_voltage_mv = '0;
  logic signed [CURR_W-1:0] in_current_ma = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DUTY_W-1:0]        out_duty;
  logic                     out_voltage_mode;
  logic                     out_duty_clamped;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  // controller shadow: registers and state
  cfg_t              cfg_m;
  logic [DUTY_W-1:0] duty_q;
  longint            integ_q;
  bit                cv_on;

  tick_t     tick_q[$];
  duty_res_t duty_exp_q[$];

  int err_cnt   = 0;
  int res_cnt   = 0;
  bit drv_busy  = 1'b0;
  bit drv_burst = 1'b0;
  int drv_gap   = 0;
  bit rcv_burst = 1'b0;
  int rcv_wait  = 0;
  tick_t nxt;

  cc_cv_pi_duty_controller u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_voltage_mv    (in_voltage_mv),
    .in_current_ma    (in_current_ma),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .out_voltage_mode (out_voltage_mode),
    .out_duty_clamped (out_duty_clamped),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    if (err_cnt < 40) $display("%0t mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int clip_int(int x, int lo, int hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // one control tick: mode switch, clamped error, incremental pi, duty update
  task automatic step_charger(logic [VOLT_W-1:0] v, logic signed [CURR_W-1:0] i);
    longint    e, kp, ki, pi, cur, hi, lo, nd;
    duty_res_t r;
    r.clamped = 1'b0;
    if (!cv_on && v > cfg_m.voltage_target) begin
      cv_on   = 1'b1;
      integ_q = 0;
    end
    if (cv_on) begin
      e  = longint'(cfg_m.voltage_target) + CV_OFFSET - longint'(v);
      kp = longint'(cfg_m.gain_p_cv);
      ki = longint'(cfg_m.gain_i_cv);
    end else begin
      e  = longint'(cfg_m.current_target) - longint'(i);
      kp = longint'(cfg_m.gain_p_cc);
      ki = longint'(cfg_m.gain_i_cc);
    end
    if (e > ERROR_HIGH) e = ERROR_HIGH;
    if (e < ERROR_LOW) e = ERROR_LOW;
    integ_q += (ki * e) / INTEGRAL_DIVISOR;
    if (integ_q > INTEG_MAX) integ_q = INTEG_MAX;
    if (integ_q < INTEG_MIN) integ_q = INTEG_MIN;
    pi  = kp * e + integ_q;
    cur = longint'(duty_q) * Q_ONE + pi;
    hi  = longint'(cfg_m.duty_max) * Q_ONE;
    lo  = longint'(cfg_m.duty_min) * Q_ONE;
    if (cur >= hi) begin
      duty_q    = cfg_m.duty_max;
      r.clamped = 1'b1;
    end else if (cur <= lo) begin
      duty_q    = cfg_m.duty_min;
      r.clamped = 1'b1;
    end else begin
      nd     = longint'(duty_q) + (pi + Q_ONE / 2) / Q_ONE;
      duty_q = nd[DUTY_W-1:0];
    end
    r.duty = duty_q;
    r.cv   = cv_on;
    duty_exp_q.push_back(r);
  endtask

  // register write, mirrored into the shadow copy
  task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CURRENT_TARGET: cfg_m.current_target = val[TGT_W-1:0];
      REG_VOLTAGE_TARGET: cfg_m.voltage_target = val[TGT_W-1:0];
      REG_GAIN_P_CC:      cfg_m.gain_p_cc      = val[GAIN_W-1:0];
      REG_GAIN_I_CC:      cfg_m.gain_i_cc      = val[GAIN_W-1:0];
      REG_GAIN_P_CV:      cfg_m.gain_p_cv      = val[GAIN_W-1:0];
      REG_GAIN_I_CV:      cfg_m.gain_i_cv      = val[GAIN_W-1:0];
      REG_DUTY_MAX:       cfg_m.duty_max       = val[DUTY_W-1:0];
      REG_DUTY_MIN:       cfg_m.duty_min       = val[DUTY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(int v, int c);
    tick_t t;
    t.v = v[VOLT_W-1:0];
    t.i = c[CURR_W-1:0];
    tick_q.push_back(t);
  endtask

  // mostly ticks near the active setpoint, the rest anywhere in range
  task automatic queue_random(int n, bit track_volt);
    int v, c;
    repeat (n) begin
      v = $urandom_range(0, 8191);
      c = int'($urandom_range(0, 16383)) - 8192;
      if ($urandom_range(0, 3) != 0) begin
        if (track_volt)
          v = clip_int(int'(cfg_m.voltage_target) + CV_OFFSET +
                       int'($urandom_range(0, 2400)) - 1200, 0, 8191);
        else
          c = clip_int(int'(cfg_m.current_target) +
                       int'($urandom_range(0, 2400)) - 1200, -8192, 8191);
      end
      push_tick(v, c);
    end
  endtask

  // wait until every item is in and every result is out, then let it settle
  task automatic settle();
    while (tick_q.size() != 0 || drv_busy || duty_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_charger(in_voltage_mv, in_current_ma);
        drv_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
        drv_gap = drv_burst ? 0 : $urandom_range(0, 9);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          in_voltage_mv <= nxt.v;
          in_current_ma <= nxt.i;
          drv_busy = 1'b1;
        end
      end
      in_valid <= drv_busy;
    end
  end

  // result monitor and receiver stalls, with two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (duty_exp_q.size() == 0) begin
          flag_mismatch("result with no item pending");
        end else begin
          duty_res_t r;
          r = duty_exp_q.pop_front();
          if (out_duty !== r.duty)
            flag_mismatch($sformatf("duty %0d, expected %0d", out_duty, r.duty));
          if (out_voltage_mode !== r.cv)
            flag_mismatch($sformatf("voltage_mode %b, expected %b", out_voltage_mode, r.cv));
          if (out_duty_clamped !== r.clamped)
            flag_mismatch($sformatf("duty_clamped %b, expected %b",
                                    out_duty_clamped, r.clamped));
        end
        res_cnt++;
        if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
        if (res_cnt == 300 || res_cnt == 1200) rcv_wait = 150;
        else rcv_wait = rcv_burst ? 0 : $urandom_range(0, 9);
      end else if (rcv_wait > 0) begin
        rcv_wait--;
      end
      out_stall <= (rcv_wait != 0);
    end
  end

  // run limit
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // stimulus phases
  initial begin
    cfg_m.current_target = '0;
    cfg_m.voltage_target = '0;
    cfg_m.gain_p_cc      = GAIN_P_CC_RST;
    cfg_m.gain_i_cc      = GAIN_I_CC_RST;
    cfg_m.gain_p_cv      = GAIN_P_CV_RST;
    cfg_m.gain_i_cv      = GAIN_I_CV_RST;
    cfg_m.duty_max       = DUTY_MAX_RST;
    cfg_m.duty_min       = DUTY_MIN_RST;
    duty_q  = '0;
    integ_q = 0;
    cv_on   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: voltage equal to target keeps current mode
    push_tick(0, -8192);
    push_tick(0, 8191);
    push_tick(0, 0);
    push_tick(0, -1);
    push_tick(0, 1);
    settle();

    // current mode, largest setpoint and gains
    set_reg(REG_VOLTAGE_TARGET, 16'd8191);
    set_reg(REG_CURRENT_TARGET, 16'd8191);
    set_reg(REG_GAIN_P_CC, 16'hFFFF);
    set_reg(REG_GAIN_I_CC, 16'hFFFF);
    set_reg(REG_DUTY_MAX, 16'd511);
    set_reg(REG_DUTY_MIN, 16'd0);
    push_tick(8191, -8192);
    push_tick(8191, 8191);
    push_tick(0, 8191);
    queue_random(230, 1'b0);
    settle();

    // zero gains, both limits at zero
    set_reg(REG_CURRENT_TARGET, 16'd0);
    set_reg(REG_GAIN_P_CC, 16'd0);
    set_reg(REG_GAIN_I_CC, 16'd0);
    set_reg(REG_DUTY_MAX, 16'd0);
    set_reg(REG_DUTY_MIN, 16'd0);
    queue_random(150, 1'b0);
    settle();

    // moderate gains, narrow duty window
    set_reg(REG_CURRENT_TARGET, 16'($urandom_range(0, 3000)));
    set_reg(REG_GAIN_P_CC, 16'($urandom_range(0, 8191)));
    set_reg(REG_GAIN_I_CC, 16'($urandom_range(0, 2047)));
    set_reg(REG_DUTY_MAX, 16'd300);
    set_reg(REG_DUTY_MIN, 16'd100);
    queue_random(250, 1'b0);
    settle();

    // crossed limits: min above max
    set_reg(REG_DUTY_MAX, 16'd50);
    set_reg(REG_DUTY_MIN, 16'd400);
    push_tick(0, -8192);
    push_tick(0, 8191);
    push_tick(100, int'(cfg_m.current_target));
    queue_random(150, 1'b0);
    settle();

    // random full-range gains, full duty window
    set_reg(REG_CURRENT_TARGET, 16'($urandom_range(0, 8191)));
    set_reg(REG_GAIN_P_CC, 16'($urandom_range(0, 65535)));
    set_reg(REG_GAIN_I_CC, 16'($urandom_range(0, 65535)));
    set_reg(REG_DUTY_MAX, 16'd511);
    set_reg(REG_DUTY_MIN, 16'd0);
    queue_random(250, 1'b0);
    settle();

    // switch to voltage mode: equal does not switch, one above does, offset gives zero error
    set_reg(REG_VOLTAGE_TARGET, 16'd2000);
    set_reg(REG_GAIN_P_CV, GAIN_P_CV_RST);
    set_reg(REG_GAIN_I_CV, GAIN_I_CV_RST);
    push_tick(2000, 0);
    push_tick(2001, 0);
    push_tick(2018, 0);
    push_tick(0, 0);
    push_tick(8191, 0);
    push_tick(100, -8192);
    queue_random(300, 1'b1);
    settle();

    // voltage mode, top target, largest p gain, no integral
    set_reg(REG_VOLTAGE_TARGET, 16'd8191);
    set_reg(REG_GAIN_P_CV, 16'hFFFF);
    set_reg(REG_GAIN_I_CV, 16'd0);
    queue_random(250, 1'b1);
    settle();

    // voltage mode, zero target, integral only
    set_reg(REG_VOLTAGE_TARGET, 16'd0);
    set_reg(REG_GAIN_P_CV, 16'd0);
    set_reg(REG_GAIN_I_CV, 16'hFFFF);
    set_reg(REG_DUTY_MAX, 16'd400);
    set_reg(REG_DUTY_MIN, 16'd20);
    queue_random(200, 1'b1);
    settle();

    // voltage mode, random gains, crossed limits
    set_reg(REG_VOLTAGE_TARGET, 16'($urandom_range(0, 8191)));
    set_reg(REG_GAIN_P_CV, 16'($urandom_range(0, 65535)));
    set_reg(REG_GAIN_I_CV, 16'($urandom_range(0, 65535)));
    set_reg(REG_DUTY_MAX, 16'd300);
    set_reg(REG_DUTY_MIN, 16'd450);
    queue_random(100, 1'b1);
    settle();

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== cc_cv_pi_duty_controller.f =====
src/ccpi_pkg.sv
src/ccpi_cfg.sv
src/ccpi_err.sv
src/ccpi_mul.sv
src/ccpi_acc.sv
src/cc_cv_pi_duty_controller.sv
tb/sv/tb.sv
